// ===== rtl/core/alt_pkg.sv =====
// Shared types and constants for the annotation list tokenizer.
// No dependencies; every other file in rtl/core except alt_if refers to this package.
`timescale 1ns / 1ps

package alt_pkg;

  // Separator and number-format bytes
  localparam logic [7:0] BYTE_NUL     = 8'd0;
  localparam logic [7:0] BYTE_ANN_SEP = 8'd20;
  localparam logic [7:0] BYTE_DUR_SEP = 8'd21;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // Token tags carried on the result channel
  typedef enum logic [2:0] {
    TK_PAD        = 3'd0,
    TK_ONSET_CHAR = 3'd1,
    TK_ONSET_END  = 3'd2,
    TK_DUR_CHAR   = 3'd3,
    TK_DUR_END    = 3'd4,
    TK_TEXT_CHAR  = 3'd5,
    TK_ANN_END    = 3'd6,
    TK_LIST_END   = 3'd7
  } kind_t;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_section;
  } item_t;

  // One tagged result as held in the result register
  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] byte_out;
    logic       field_ok;
    logic       text_empty;
    logic       section_cut;
  } result_t;

endpackage

// ===== rtl/core/alt_if.sv =====
// Valid/ready channel interfaces for the annotation list tokenizer.
// Depends on nothing; payload widths follow the byte and token formats.
`timescale 1ns / 1ps

interface alt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_section;

  modport source (output valid, output data_byte, output last_in_section, input ready);
  modport sink   (input valid, input data_byte, input last_in_section, output ready);
endinterface

interface alt_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] byte_out;
  logic       field_ok;
  logic       text_empty;
  logic       section_cut;

  modport source (output valid, output token_kind, output byte_out, output field_ok,
                  output text_empty, output section_cut, input ready);
  modport sink   (input valid, input token_kind, input byte_out, input field_ok,
                  input text_empty, input section_cut, output ready);
endinterface

// ===== rtl/core/alt_tagger.sv =====
// Tagging logic: list phase and number-format flags, plus the result register.
// Depends on alt_pkg for byte constants, token kinds and the item/result structs.
`timescale 1ns / 1ps

module alt_tagger (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  alt_pkg::item_t  item,
  output alt_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_ONSET_START = 3'd0,
    PH_ONSET       = 3'd1,
    PH_DURATION    = 3'd2,
    PH_TEXT        = 3'd3,
    PH_PAD         = 3'd4
  } phase_t;

  phase_t phase, phase_next;
  logic   dot_seen, dot_seen_next;
  logic   last_was_dot, last_was_dot_next;
  logic   field_bad, field_bad_next;
  logic   text_seen, text_seen_next;

  alt_pkg::kind_t kind;
  logic           ok, empty, cut;
  logic [7:0]     b;
  logic           is_nul, is_ann_sep, is_dur_sep, is_digit, is_dot, is_sign;

  // Classify the current byte
  always_comb begin
    b          = item.data_byte;
    is_nul     = (b == alt_pkg::BYTE_NUL);
    is_ann_sep = (b == alt_pkg::BYTE_ANN_SEP);
    is_dur_sep = (b == alt_pkg::BYTE_DUR_SEP);
    is_digit   = (b >= alt_pkg::CHAR_ZERO) && (b <= alt_pkg::CHAR_NINE);
    is_dot     = (b == alt_pkg::CHAR_DOT);
    is_sign    = (b == alt_pkg::CHAR_PLUS) || (b == alt_pkg::CHAR_MINUS);
  end

  // Tag the byte and work out the next phase and flags
  always_comb begin
    phase_next        = phase;
    dot_seen_next     = dot_seen;
    last_was_dot_next = last_was_dot;
    field_bad_next    = field_bad;
    text_seen_next    = text_seen;
    kind              = alt_pkg::TK_PAD;
    ok                = 1'b0;
    empty             = 1'b0;
    cut               = 1'b0;

    case (phase)
      PH_ONSET_START: begin
        dot_seen_next     = 1'b0;
        last_was_dot_next = 1'b0;
        field_bad_next    = 1'b0;
        text_seen_next    = 1'b0;
        if (is_nul) begin
          kind       = alt_pkg::TK_PAD;
          phase_next = PH_PAD;
        end else if (is_ann_sep || is_dur_sep) begin
          // empty onset: no sign, so never valid
          kind       = alt_pkg::TK_ONSET_END;
          phase_next = is_dur_sep ? PH_DURATION : PH_TEXT;
        end else begin
          kind           = alt_pkg::TK_ONSET_CHAR;
          field_bad_next = !is_sign;
          phase_next     = PH_ONSET;
        end
      end
      PH_ONSET, PH_DURATION: begin
        if ((phase == PH_ONSET) && (is_ann_sep || is_dur_sep)) begin
          kind       = alt_pkg::TK_ONSET_END;
          ok         = !field_bad && !last_was_dot;
          phase_next = is_dur_sep ? PH_DURATION : PH_TEXT;
        end else if ((phase == PH_DURATION) && is_ann_sep) begin
          kind       = alt_pkg::TK_DUR_END;
          ok         = !field_bad;
          phase_next = PH_TEXT;
        end else begin
          kind = (phase == PH_ONSET) ? alt_pkg::TK_ONSET_CHAR : alt_pkg::TK_DUR_CHAR;
        end

        if (phase_next != phase) begin
          // field closed: drop its flags
          dot_seen_next     = 1'b0;
          last_was_dot_next = 1'b0;
          field_bad_next    = 1'b0;
          text_seen_next    = 1'b0;
        end else if (is_dot && !dot_seen) begin
          dot_seen_next     = 1'b1;
          last_was_dot_next = 1'b1;
        end else if (is_digit) begin
          last_was_dot_next = 1'b0;
        end else begin
          field_bad_next    = 1'b1;
          last_was_dot_next = 1'b0;
        end
      end
      PH_TEXT: begin
        if (is_ann_sep) begin
          kind           = alt_pkg::TK_ANN_END;
          empty          = !text_seen;
          text_seen_next = 1'b0;
        end else if (is_nul && !text_seen) begin
          // zero right after a separator closes the list
          kind              = alt_pkg::TK_LIST_END;
          dot_seen_next     = 1'b0;
          last_was_dot_next = 1'b0;
          field_bad_next    = 1'b0;
          text_seen_next    = 1'b0;
          phase_next        = PH_ONSET_START;
        end else begin
          kind           = alt_pkg::TK_TEXT_CHAR;
          text_seen_next = 1'b1;
        end
      end
      default: begin
        kind       = alt_pkg::TK_PAD;
        phase_next = PH_PAD;
      end
    endcase

    // Section end: flag an unfinished list and start over
    if (item.last_in_section) begin
      cut               = (phase_next != PH_ONSET_START) && (phase_next != PH_PAD);
      phase_next        = PH_ONSET_START;
      dot_seen_next     = 1'b0;
      last_was_dot_next = 1'b0;
      field_bad_next    = 1'b0;
      text_seen_next    = 1'b0;
    end
  end

  // Hold state and the result register; advance on each moved beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ONSET_START;
      dot_seen     <= 1'b0;
      last_was_dot <= 1'b0;
      field_bad    <= 1'b0;
      text_seen    <= 1'b0;
    end else if (adv) begin
      phase              <= phase_next;
      dot_seen           <= dot_seen_next;
      last_was_dot       <= last_was_dot_next;
      field_bad          <= field_bad_next;
      text_seen          <= text_seen_next;
      result.token_kind  <= kind;
      result.byte_out    <= b;
      result.field_ok    <= ok;
      result.text_empty  <= empty;
      result.section_cut <= cut;
    end
  end

endmodule

// ===== rtl/core/annotation_list_tokenizer.sv =====
// Top level of the annotation list tokenizer: input register, tagger, result channel.
// Depends on alt_pkg, alt_byte_if / alt_token_if and alt_tagger.
`timescale 1ns / 1ps

// Usage
//   byte_ch  : one beat per byte of a record's annotation section; set
//              last_in_section on the final byte of the section.
//   token_ch : one beat per input byte, in order, carrying its tag (padding,
//              onset/duration char or end, text char, annotation end, list
//              end), the byte itself, the format check at field ends, the
//              empty-text flag at annotation ends and the cut flag on the
//              section's last byte.
//   Throughput: one byte per cycle while token_ch.ready is high; the phase
//   register and its flags are updated as each byte moves on, so consecutive
//   bytes never wait on each other. Path: a byte accepted is held in the
//   input register, then tagged into the result register and offered on
//   token_ch from then on.
//   Stall: while token_ch.ready is low the result is held, one more byte is
//   taken into the input register, and then byte_ch.ready drops.
//   Reset: synchronous; both stages empty, phase back to onset start,
//   all format flags cleared.
module annotation_list_tokenizer (
  input logic          clk,
  input logic          rst,
  alt_byte_if.sink     byte_ch,
  alt_token_if.source  token_ch
);

  logic             in_valid;
  alt_pkg::item_t   in_item;
  logic             out_valid;
  logic             adv;
  alt_pkg::result_t result;

  // Move the held byte into the result stage when that stage is free
  assign adv           = in_valid && (!out_valid || token_ch.ready);
  assign byte_ch.ready = !in_valid || adv;

  // Hold stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (byte_ch.ready) begin
        in_valid <= byte_ch.valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (token_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      in_item.data_byte       <= byte_ch.data_byte;
      in_item.last_in_section <= byte_ch.last_in_section;
    end
  end

  alt_tagger u_tagger (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (in_item),
    .result (result)
  );

  // Drive the result channel
  assign token_ch.valid       = out_valid;
  assign token_ch.token_kind  = result.token_kind;
  assign token_ch.byte_out    = result.byte_out;
  assign token_ch.field_ok    = result.field_ok;
  assign token_ch.text_empty  = result.text_empty;
  assign token_ch.section_cut = result.section_cut;

  // A format verdict only accompanies a field end
  a_ok_at_field_end : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.field_ok) |->
      (result.token_kind == alt_pkg::TK_ONSET_END ||
       result.token_kind == alt_pkg::TK_DUR_END))
    else $error("field_ok outside a field end");

  // An empty-text flag only accompanies an annotation end
  a_empty_at_ann_end : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.text_empty) |-> (result.token_kind == alt_pkg::TK_ANN_END))
    else $error("text_empty outside an annotation end");

  // A closed list or padding is never reported as cut
  a_cut_not_closed : assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.section_cut) |->
      (result.token_kind != alt_pkg::TK_LIST_END && result.token_kind != alt_pkg::TK_PAD))
    else $error("section_cut on list end or padding");

  // A stalled result with a full input stage blocks new bytes
  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !token_ch.ready) |-> !byte_ch.ready)
    else $error("byte accepted while both stages are full");

  // Stages come up empty after reset
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid))
    else $error("stage valid after reset");

endmodule

// ===== tb/tb_annotation_list_tokenizer.sv =====
// Self-checking testbench for the annotation list tokenizer: directed and random
// annotation sections, a scoreboard class that predicts every byte's tag.
// Depends on alt_pkg, alt_byte_if / alt_token_if and annotation_list_tokenizer.
`timescale 1ns / 1ps

module tb_annotation_list_tokenizer;

  localparam int RANDOM_BYTES = 510;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // Parse position inside a list
  typedef enum logic [2:0] {
    PH_ONSET_START,
    PH_ONSET,
    PH_DURATION,
    PH_TEXT,
    PH_PAD
  } phase_t;

  // Tag predictor and queue of expected tags
  class token_scoreboard;
    phase_t           phase;
    bit               dot_seen;
    bit               last_was_dot;
    bit               field_bad;
    bit               text_seen;
    alt_pkg::result_t expected_q[$];
    int               errors;
    int               checked;
    int               cut_count;
    int               kind_count[8];

    function new();
      phase = PH_ONSET_START;
      clear_flags();
      errors = 0;
      checked = 0;
      cut_count = 0;
    endfunction

    function void clear_flags();
      dot_seen = 0;
      last_was_dot = 0;
      field_bad = 0;
      text_seen = 0;
    endfunction

    // Track one number character: at most one dot, digits otherwise
    function void take_number_char(logic [7:0] b);
      if (b == alt_pkg::CHAR_DOT && !dot_seen) begin
        dot_seen = 1;
        last_was_dot = 1;
      end else if (b >= alt_pkg::CHAR_ZERO && b <= alt_pkg::CHAR_NINE) begin
        last_was_dot = 0;
      end else begin
        field_bad = 1;
        last_was_dot = 0;
      end
    endfunction

    // Predict the tag of one accepted byte and queue it
    function void note_byte(logic [7:0] b, logic last);
      alt_pkg::result_t t;
      t.token_kind  = alt_pkg::TK_PAD;
      t.byte_out    = b;
      t.field_ok    = 1'b0;
      t.text_empty  = 1'b0;
      t.section_cut = 1'b0;
      case (phase)
        PH_ONSET_START: begin
          clear_flags();
          if (b == alt_pkg::BYTE_NUL) begin
            phase = PH_PAD;
          end else if (b == alt_pkg::BYTE_ANN_SEP || b == alt_pkg::BYTE_DUR_SEP) begin
            t.token_kind = alt_pkg::TK_ONSET_END;
            phase = (b == alt_pkg::BYTE_DUR_SEP) ? PH_DURATION : PH_TEXT;
          end else begin
            t.token_kind = alt_pkg::TK_ONSET_CHAR;
            if (b != alt_pkg::CHAR_PLUS && b != alt_pkg::CHAR_MINUS) field_bad = 1;
            phase = PH_ONSET;
          end
        end
        PH_ONSET: begin
          if (b == alt_pkg::BYTE_ANN_SEP || b == alt_pkg::BYTE_DUR_SEP) begin
            t.token_kind = alt_pkg::TK_ONSET_END;
            t.field_ok = !field_bad && !last_was_dot;
            clear_flags();
            phase = (b == alt_pkg::BYTE_DUR_SEP) ? PH_DURATION : PH_TEXT;
          end else begin
            t.token_kind = alt_pkg::TK_ONSET_CHAR;
            take_number_char(b);
          end
        end
        PH_DURATION: begin
          if (b == alt_pkg::BYTE_ANN_SEP) begin
            t.token_kind = alt_pkg::TK_DUR_END;
            t.field_ok = !field_bad;
            clear_flags();
            phase = PH_TEXT;
          end else begin
            t.token_kind = alt_pkg::TK_DUR_CHAR;
            take_number_char(b);
          end
        end
        PH_TEXT: begin
          if (b == alt_pkg::BYTE_ANN_SEP) begin
            t.token_kind = alt_pkg::TK_ANN_END;
            t.text_empty = !text_seen;
            text_seen = 0;
          end else if (b == alt_pkg::BYTE_NUL && !text_seen) begin
            t.token_kind = alt_pkg::TK_LIST_END;
            clear_flags();
            phase = PH_ONSET_START;
          end else begin
            t.token_kind = alt_pkg::TK_TEXT_CHAR;
            text_seen = 1;
          end
        end
        default: begin
          phase = PH_PAD;
        end
      endcase
      // Section end: flag an unfinished list, then start over
      if (last) begin
        t.section_cut = (phase != PH_ONSET_START && phase != PH_PAD);
        phase = PH_ONSET_START;
        clear_flags();
      end
      expected_q.insert(expected_q.size(), t);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      if (errors < 30) $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one accepted result with the oldest expected tag
    task check_token(alt_pkg::result_t got);
      alt_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d byte %0d",
                                  got.token_kind, got.byte_out));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      kind_count[want.token_kind]++;
      if (want.section_cut) cut_count++;
      if (got.token_kind !== want.token_kind)
        report_mismatch($sformatf("token %0d: kind %0d, want %0d",
                                  checked, got.token_kind, want.token_kind));
      if (got.byte_out !== want.byte_out)
        report_mismatch($sformatf("token %0d: byte %0d, want %0d",
                                  checked, got.byte_out, want.byte_out));
      if (got.field_ok !== want.field_ok)
        report_mismatch($sformatf("token %0d: field_ok %b, want %b",
                                  checked, got.field_ok, want.field_ok));
      if (got.text_empty !== want.text_empty)
        report_mismatch($sformatf("token %0d: text_empty %b, want %b",
                                  checked, got.text_empty, want.text_empty));
      if (got.section_cut !== want.section_cut)
        report_mismatch($sformatf("token %0d: section_cut %b, want %b",
                                  checked, got.section_cut, want.section_cut));
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   section_count;

  alt_byte_if  byte_ch ();
  alt_token_if token_ch ();

  token_scoreboard sb;
  alt_pkg::item_t  stim_q[$];
  logic [7:0]      section_q[$];

  annotation_list_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .token_ch (token_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_annotation_list_tokenizer NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic put(input logic [7:0] b, input logic last);
    alt_pkg::item_t it;
    it.data_byte = b;
    it.last_in_section = last;
    stim_q.insert(stim_q.size(), it);
  endtask

  // Append one byte to the section under construction
  function automatic void add_byte(logic [7:0] b);
    section_q.insert(section_q.size(), b);
  endfunction

  function automatic logic [7:0] pick_digit();
    return alt_pkg::CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == alt_pkg::BYTE_ANN_SEP || b == alt_pkg::BYTE_DUR_SEP);
    return b;
  endfunction

  function automatic logic [7:0] pick_text_byte(bit leading);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == alt_pkg::BYTE_ANN_SEP || (leading && b == alt_pkg::BYTE_NUL));
    return b;
  endfunction

  // Append an onset or duration, now and then malformed
  function automatic void add_number(bit with_sign);
    int n;
    int dot_at;
    int r;
    int k;
    n = $urandom_range(6);
    dot_at = $urandom_range(1) ? int'($urandom_range(n)) : -1;
    r = $urandom_range(99);
    if (with_sign) add_byte($urandom_range(1) ? alt_pkg::CHAR_PLUS : alt_pkg::CHAR_MINUS);
    for (k = 0; k < n; k++) begin
      if (k == dot_at) add_byte(alt_pkg::CHAR_DOT);
      add_byte(pick_digit());
    end
    if (dot_at == n) add_byte(alt_pkg::CHAR_DOT);
    if (r < 6) add_byte(alt_pkg::CHAR_DOT);
    else if (r < 14) add_byte(pick_junk());
  endfunction

  // Append one list: onset, optional duration, annotations, list end
  function automatic void add_list();
    int nann;
    int len;
    int a;
    int j;
    add_number($urandom_range(9) != 0);
    if ($urandom_range(1)) begin
      add_byte(alt_pkg::BYTE_DUR_SEP);
      add_number(1'b0);
    end
    add_byte(alt_pkg::BYTE_ANN_SEP);
    nann = $urandom_range(3);
    for (a = 0; a < nann; a++) begin
      len = $urandom_range(6);
      for (j = 0; j < len; j++) add_byte(pick_text_byte(j == 0));
      add_byte(alt_pkg::BYTE_ANN_SEP);
    end
    add_byte(alt_pkg::BYTE_NUL);
  endfunction

  // Append one section: mostly well-formed lists, sometimes noise or cut short
  task automatic add_section();
    int r;
    int n;
    int k;
    int end_at;
    logic [7:0] b;
    section_q.delete();
    r = $urandom_range(99);
    if (r < 10) begin
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(5))
          0: b = alt_pkg::BYTE_NUL;
          1: b = alt_pkg::BYTE_ANN_SEP;
          2: b = alt_pkg::BYTE_DUR_SEP;
          3: b = $urandom_range(1) ? alt_pkg::CHAR_PLUS : alt_pkg::CHAR_DOT;
          4: b = pick_digit();
          default: b = 8'($urandom_range(255));
        endcase
        add_byte(b);
      end
    end else begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) add_list();
      if ($urandom_range(99) < 40) begin
        add_byte(alt_pkg::BYTE_NUL);
        n = $urandom_range(5);
        for (k = 0; k < n; k++) add_byte(8'($urandom_range(255)));
      end
    end
    end_at = section_q.size() - 1;
    if ($urandom_range(99) < 15) end_at = $urandom_range(end_at);
    for (k = 0; k <= end_at; k++) put(section_q[k], k == end_at);
    section_count++;
  endtask

  // Directed sections: sign, duration, odd text, empty fields, bad formats, padding
  task automatic add_directed();
    // plus sign, duration, text with a zero after its first char, empty annotation
    put(alt_pkg::CHAR_PLUS, 0); put(alt_pkg::CHAR_ZERO, 0);
    put(alt_pkg::BYTE_DUR_SEP, 0); put(alt_pkg::CHAR_NINE, 0);
    put(alt_pkg::BYTE_ANN_SEP, 0); put(8'hFF, 0); put(alt_pkg::BYTE_NUL, 0);
    put(alt_pkg::BYTE_ANN_SEP, 0);
    put(alt_pkg::BYTE_ANN_SEP, 0); put(alt_pkg::BYTE_NUL, 0);
    // sign-only onset
    put(alt_pkg::CHAR_MINUS, 0); put(alt_pkg::BYTE_ANN_SEP, 0); put(alt_pkg::BYTE_NUL, 0);
    // empty onset into text
    put(alt_pkg::BYTE_ANN_SEP, 0); put(alt_pkg::BYTE_NUL, 0);
    // empty onset into an empty duration; section ends on the list end
    put(alt_pkg::BYTE_DUR_SEP, 0); put(alt_pkg::BYTE_ANN_SEP, 0); put(alt_pkg::BYTE_NUL, 1);
    // trailing-dot onset, duration with stray 21, second dot and zero
    put(alt_pkg::CHAR_PLUS, 0); put(alt_pkg::CHAR_DOT, 0);
    put(alt_pkg::BYTE_DUR_SEP, 0); put(alt_pkg::CHAR_DOT, 0);
    put(alt_pkg::BYTE_DUR_SEP, 0); put(alt_pkg::CHAR_DOT, 0);
    put(alt_pkg::BYTE_NUL, 0); put(alt_pkg::BYTE_ANN_SEP, 0);
    put(alt_pkg::BYTE_NUL, 0);
    // padding closes the section
    put(alt_pkg::BYTE_NUL, 1);
    // unsigned onset cut off by the section end
    put(alt_pkg::CHAR_NINE, 1);
    section_count += 3;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte after random idle cycles, hold until accepted
  task automatic send_byte(input alt_pkg::item_t it, input bit gaps_on);
    while (gaps_on && $urandom_range(99) < 24) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid           <= 1'b1;
    byte_ch.data_byte       <= it.data_byte;
    byte_ch.last_in_section <= it.last_in_section;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sb.note_byte(it.data_byte, it.last_in_section);
  endtask

  // Take results with random stalls; no stalls through a middle stretch
  always @(posedge clk) begin
    if (rst) begin
      token_ch.ready <= 1'b0;
    end else begin
      if (token_ch.valid && token_ch.ready)
        sb.check_token({token_ch.token_kind, token_ch.byte_out, token_ch.field_ok,
                        token_ch.text_empty, token_ch.section_cut});
      if (sb.checked >= 280 && sb.checked < 420) token_ch.ready <= 1'b1;
      else token_ch.ready <= ($urandom_range(99) >= 24);
    end
  end

  initial begin
    int i;
    sb = new();
    section_count = 0;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_in_section <= 1'b0;
    add_directed();
    i = stim_q.size();
    while (stim_q.size() < i + RANDOM_BYTES) add_section();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Feed every byte; the sender never idles through a middle stretch
    for (i = 0; i < stim_q.size(); i++) send_byte(stim_q[i], !(i >= 250 && i < 350));
    byte_ch.valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Tagged %0d bytes in %0d sections: %0d list ends, %0d annotation ends,",
             sb.checked, section_count, sb.kind_count[alt_pkg::TK_LIST_END],
             sb.kind_count[alt_pkg::TK_ANN_END]);
    $display("%0d padding bytes, %0d cut sections, %0d mismatches.",
             sb.kind_count[alt_pkg::TK_PAD], sb.cut_count, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_annotation_list_tokenizer OK");
    end else begin
      $display("tb_annotation_list_tokenizer NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/alt_pkg.sv
rtl/core/alt_if.sv
rtl/core/alt_tagger.sv
rtl/core/annotation_list_tokenizer.sv
tb/tb_annotation_list_tokenizer.sv
